// File: src/ogcg_pkg.sv
package ogcg_pkg;

  localparam int unsigned NodesDefault = 32;
  localparam int unsigned NodeW        = 5;

endpackage

// File: src/order_graph_cycle_guard.sv
// Edge guard for two directed graphs, lock order (opcode 0) and thread join (opcode 1), held
// as adjacency rows in one internal memory. Each input word asks to add from_node -> to_node;
// the block answers with one status word: 0 when the edge is added or already present, 1 when
// it is refused as a self edge, an out-of-range node, or because it would close a cycle. The
// check walks the nodes reachable from to_node through a single memory read port, picking each
// node and reading its row in one state (StPick) and merging that row in another (StExpand). A
// self edge or an out-of-range node goes straight to the final state; a walk that expands every
// node but from_node adds the edge in a write state, and the final state hands over the result,
// holding while the output stalls. The input stalls for the whole walk. Both graphs are empty
// after reset with no clearing pass.
module order_graph_cycle_guard
  import ogcg_pkg::*;
#(
  parameter int unsigned NODES = NodesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             opcode_i,
  input  logic [NodeW-1:0] from_node_i,
  input  logic [NodeW-1:0] to_node_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             status_o
);

  localparam int unsigned IdxW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CmpW = NodeW + 2;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StPick   = 3'd1;
  localparam logic [2:0] StExpand = 3'd2;
  localparam logic [2:0] StWrite  = 3'd3;
  localparam logic [2:0] StFin    = 3'd4;

  logic [2:0] state_q, state_d;
  logic [NODES-1:0] pending_q, pending_d;
  logic [NODES-1:0] visited_q, visited_d;
  logic sel_q, sel_d;
  logic [IdxW-1:0] src_q, src_d;
  logic [IdxW-1:0] dst_q, dst_d;
  logic result_q, result_d;
  logic out_valid_q, out_valid_d;
  logic status_q, status_d;

  logic [NODES-1:0] rows_mem [2][NODES];
  logic [1:0][NODES-1:0] row_valid_q;
  logic [NODES-1:0] rd_data_q;
  logic rd_valid_q;
  logic [NODES-1:0] row;

  logic rd_en;
  logic [IdxW-1:0] rd_addr;
  logic wr_en;
  logic [NODES-1:0] wr_data;

  logic accept;
  logic bad_node;
  logic [IdxW-1:0] pick;
  logic slot_free;

  always_comb begin
    pick = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (pending_q[i]) begin
        pick = IdxW'(i);
      end
    end
  end

  assign accept    = in_valid_i && (state_q == StIdle);
  assign bad_node  = (CmpW'(from_node_i) >= CmpW'(NODES)) || (CmpW'(to_node_i) >= CmpW'(NODES))
                     || (from_node_i == to_node_i);
  assign row       = rd_valid_q ? rd_data_q : '0;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign wr_data   = row | (NODES'(1) << dst_q);

  always_comb begin
    state_d     = state_q;
    pending_d   = pending_q;
    visited_d   = visited_q;
    sel_d       = sel_q;
    src_d       = src_q;
    dst_d       = dst_q;
    result_d    = result_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    rd_en       = 1'b0;
    rd_addr     = pick;
    wr_en       = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          sel_d     = opcode_i;
          src_d     = IdxW'(from_node_i);
          dst_d     = IdxW'(to_node_i);
          visited_d = '0;
          pending_d = NODES'(1) << IdxW'(to_node_i);
          if (bad_node) begin
            result_d = 1'b1;
            state_d  = StFin;
          end else begin
            state_d = StPick;
          end
        end
      end
      StPick: begin
        if (pending_q == '0) begin
          rd_en   = 1'b1;
          rd_addr = src_q;
          state_d = StWrite;
        end else begin
          pending_d[pick] = 1'b0;
          visited_d[pick] = 1'b1;
          if (pick == src_q) begin
            result_d = 1'b1;
            state_d  = StFin;
          end else begin
            rd_en   = 1'b1;
            state_d = StExpand;
          end
        end
      end
      StExpand: begin
        pending_d = pending_q | (row & ~visited_q);
        state_d   = StPick;
      end
      StWrite: begin
        wr_en    = 1'b1;
        result_d = 1'b0;
        state_d  = StFin;
      end
      StFin: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          status_d    = result_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (wr_en) begin
        row_valid_q[sel_q][src_q] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= row_valid_q[sel_q][rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pending_q <= pending_d;
    visited_q <= visited_d;
    sel_q     <= sel_d;
    src_q     <= src_d;
    dst_q     <= dst_d;
    result_q  <= result_d;
    status_q  <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rows_mem[sel_q][src_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= rows_mem[sel_q][rd_addr];
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_sets_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPick) |-> ((pending_q & visited_q) == '0))
    else $error("pending and visited sets overlap");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != StIdle))
    else $error("accepted word did not start a check");

  a_write_unreached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite) |-> !visited_q[src_q])
    else $error("edge written although source was reached");

  a_fin_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite) |=> (state_q == StFin) && !result_q)
    else $error("added edge not reported as added");
`endif

endmodule
